// ----- rtl/upd_pkg.sv -----
package upd_pkg;

   localparam int unsigned MaxResults = 3;

   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharSpace   = 8'h20;

   // register indexes on the csr port
   localparam logic RegStopOnZero = 1'b0;

   typedef enum logic [1:0] {
      HELD_NONE  = 2'd0,
      HELD_PCT   = 2'd1,
      HELD_DIGIT = 2'd2
   } held_type;

   typedef struct packed {
      logic [1:0]                  count;
      logic [MaxResults-1:0][7:0]  bytes;
      logic [MaxResults-1:0]       lasts;
   } bundle_type;

   typedef struct packed {
      held_type    held;
      logic [7:0]  digit;
      logic        dropping;
   } dec_state_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end
      hex_value = v[3:0];
   endfunction

endpackage

// ----- rtl/url_percent_decoder_unit.sv -----
// latency: the first result of an item is valid in the cycle after the item is taken
// throughput: one item per cycle while items decode to at most one result each and rsp_stall is low;
//   an item with several results holds the result slot, and the next item,
//   even one that yields no results, waits until the last of them is taken
// reset (synchronous, active high) clears stop_on_zero, pending bytes, truncation and the result slot
module url_percent_decoder_unit import upd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // encoded byte stream in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   // decoded byte stream out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   // apb-style register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration register
   logic stop_ff, stop_in;
   logic csr_wr;

   // decoder state: pending '%' / digit and truncation flag
   dec_state_type st_ff, st_in, st_nxt;

   bundle_type bundle;
   logic       emit_ready;
   logic       req_take;
   logic       load;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign stop_in    = (csr_wr && csr_paddr[2] == RegStopOnZero) ? csr_pwdata[0] : stop_ff;
   assign csr_prdata = (csr_paddr[2] == RegStopOnZero) ? {31'd0, stop_ff} : 32'd0;

   // the item is taken as soon as the result slot can hold its results;
   // items that yield nothing only touch the decoder state
   assign req_stall = !emit_ready;
   assign req_take  = req_valid && emit_ready;
   assign load      = req_take && (bundle.count != 2'd0);
   assign st_in     = req_take ? st_nxt : st_ff;

   upd_decode u_decode (
      .in_byte      (req_in_byte),
      .in_last      (req_in_last),
      .stop_on_zero (stop_ff),
      .cur          (st_ff),
      .nxt          (st_nxt),
      .bundle       (bundle)
   );

   // result slot: holds up to three decoded bytes and hands them out one a cycle while rsp_stall is low
   upd_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .bundle       (bundle),
      .ready        (emit_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff        <= 1'b0;
         st_ff.held     <= HELD_NONE;
         st_ff.digit    <= 8'h00;
         st_ff.dropping <= 1'b0;
      end else begin
         stop_ff <= stop_in;
         st_ff   <= st_in;
      end
   end

   // a held digit is always a hex digit
   a_digit_hex: assert property (@(posedge clock) disable iff (reset)
      (st_ff.held == HELD_DIGIT) |-> is_hex(st_ff.digit))
      else $error("pending digit is not hex");

   // while truncating, nothing is pending
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      st_ff.dropping |-> (st_ff.held == HELD_NONE))
      else $error("pending bytes while dropping");

   // a last input item leaves nothing pending and ends truncation
   a_last_flush: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_in_last) |=> (st_ff.held == HELD_NONE && !st_ff.dropping))
      else $error("state not flushed after last item");

endmodule

// ----- rtl/upd_decode.sv -----
module upd_decode import upd_pkg::*; (
   input  logic [7:0]    in_byte,
   input  logic          in_last,
   input  logic          stop_on_zero,
   input  dec_state_type cur,
   output dec_state_type nxt,
   output bundle_type    bundle
);

   logic       hv_ok;
   logic [7:0] value;
   logic       p_hold;
   logic [7:0] p_byte;

   assign hv_ok = is_hex(in_byte);
   assign value = {hex_value(cur.digit), hex_value(in_byte)};

   // plain decode of the current byte with nothing pending
   assign p_hold = (in_byte == CharPercent) && !in_last;
   assign p_byte = (in_byte == CharPlus) ? CharSpace : in_byte;

   always_comb begin
      nxt          = cur;
      nxt.held     = HELD_NONE;
      bundle.count = 2'd0;
      bundle.bytes = '0;
      bundle.lasts = '0;
      if (cur.dropping) begin
         nxt.held     = cur.held;
         nxt.dropping = !in_last;
      end else begin
         case (cur.held)
            HELD_PCT: begin
               if (hv_ok && !in_last) begin
                  nxt.held  = HELD_DIGIT;
                  nxt.digit = in_byte;
               end else begin
                  bundle.bytes[0] = CharPercent;
                  if (p_hold) begin
                     nxt.held     = HELD_PCT;
                     bundle.count = 2'd1;
                  end else begin
                     bundle.bytes[1] = p_byte;
                     bundle.lasts[1] = in_last;
                     bundle.count    = 2'd2;
                  end
               end
            end
            HELD_DIGIT: begin
               if (hv_ok) begin
                  bundle.count = 2'd1;
                  if (value == 8'h00 && stop_on_zero) begin
                     bundle.bytes[0] = CharPercent;
                     bundle.lasts[0] = 1'b1;
                     nxt.dropping    = !in_last;
                  end else begin
                     bundle.bytes[0] = value;
                     bundle.lasts[0] = in_last;
                  end
               end else begin
                  bundle.bytes[0] = CharPercent;
                  bundle.bytes[1] = cur.digit;
                  if (p_hold) begin
                     nxt.held     = HELD_PCT;
                     bundle.count = 2'd2;
                  end else begin
                     bundle.bytes[2] = p_byte;
                     bundle.lasts[2] = in_last;
                     bundle.count    = 2'd3;
                  end
               end
            end
            default: begin
               if (p_hold) begin
                  nxt.held = HELD_PCT;
               end else begin
                  bundle.bytes[0] = p_byte;
                  bundle.lasts[0] = in_last;
                  bundle.count    = 2'd1;
               end
            end
         endcase
      end
   end

endmodule

// ----- rtl/upd_emit.sv -----
module upd_emit import upd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle,
   output logic       ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   bundle_type bnd_ff, bnd_in;
   logic       take;
   logic       final_slot;

   assign take       = valid_ff && !rsp_stall;
   assign final_slot = (idx_ff == bnd_ff.count - 2'd1);
   assign ready      = !valid_ff || (take && final_slot);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      bnd_in   = bnd_ff;
      if (take) begin
         idx_in = idx_ff + 2'd1;
         if (final_slot) begin
            valid_in = 1'b0;
         end
      end
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
         bnd_in   = bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      bnd_ff <= bnd_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = bnd_ff.bytes[idx_ff];
   assign rsp_out_last = bnd_ff.lasts[idx_ff];

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < bnd_ff.count))
      else $error("slot index beyond bundle count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> ready)
      else $error("bundle loaded while results still pending");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (take && final_slot && !load) |=> !valid_ff)
      else $error("bundle still valid after its final result");

   a_empty_bundle: assert property (@(posedge clock) disable iff (reset)
      load |-> (bundle.count != 2'd0))
      else $error("bundle loaded with no results");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
   import upd_pkg::*;

   // byte addresses on the register port
   localparam logic [2:0] AddrStopOnZero = {RegStopOnZero, 2'b00};
   // first address past the register list, writes there are ignored
   localparam logic [2:0] AddrBeyondList = AddrStopOnZero + 3'd4;

   localparam int unsigned CycleLimit     = 200000;
   localparam int unsigned HoldoffCycles  = 400;
   localparam int unsigned SettleCycles   = 4;
   localparam int unsigned ItemsPerPhase  = 95;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } coded_byte_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } plain_byte_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   url_percent_decoder_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always #5 clock = ~clock;

   // encoded bytes waiting for the sender, decoded bytes waiting for the output
   coded_byte_type to_send[$];
   plain_byte_type expected_decoded[$];

   // decoder state as predicted
   logic        pred_stop_on_zero = 1'b0;
   held_type    pred_held = HELD_NONE;
   logic [7:0]  pred_digit = 8'h00;
   logic        pred_dropping = 1'b0;

   int unsigned fail_count = 0;
   int unsigned items_queued = 0;
   int unsigned items_taken = 0;
   int unsigned strings_queued = 0;
   int unsigned bytes_checked = 0;
   int unsigned truncations = 0;
   int unsigned cycle_count = 0;
   int unsigned holdoff_requests = 0;

   // ---------------------------------------------------------------- predictor

   function automatic logic hex_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= "0" && c <= "9") begin
         v = c - "0";
      end else if (c >= "A" && c <= "F") begin
         v = c - "A" + 8'd10;
      end else if (c >= "a" && c <= "f") begin
         v = c - "a" + 8'd10;
      end
      return v[3:0];
   endfunction

   task automatic expect_byte(input logic [7:0] b, input logic l);
      expected_decoded.push_back('{data: b, last: l});
   endtask

   // decode with nothing pending: a '%' that is not the last byte opens an escape
   task automatic decode_plain(input logic [7:0] b, input logic l);
      if (b == CharPercent && !l) begin
         pred_held = HELD_PCT;
      end else begin
         expect_byte((b == CharPlus) ? CharSpace : b, l);
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic l);
      logic [7:0] value;
      // rest of a truncated string is swallowed up to its last byte
      if (pred_dropping) begin
         if (l) pred_dropping = 1'b0;
         return;
      end
      case (pred_held)
         HELD_PCT: begin
            pred_held = HELD_NONE;
            if (hex_char(b) && !l) begin
               pred_held = HELD_DIGIT;
               pred_digit = b;
            end else begin
               // broken or short escape, '%' goes out literally
               expect_byte(CharPercent, 1'b0);
               decode_plain(b, l);
            end
         end
         HELD_DIGIT: begin
            pred_held = HELD_NONE;
            if (hex_char(b)) begin
               value = {hex_nibble(pred_digit), hex_nibble(b)};
               if (value == 8'h00 && pred_stop_on_zero) begin
                  // encoded zero ends the output with a '%'
                  expect_byte(CharPercent, 1'b1);
                  pred_dropping = !l;
                  truncations++;
               end else begin
                  expect_byte(value, l);
               end
            end else begin
               expect_byte(CharPercent, 1'b0);
               expect_byte(pred_digit, 1'b0);
               decode_plain(b, l);
            end
         end
         default: begin
            pred_held = HELD_NONE;
            decode_plain(b, l);
         end
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   task automatic queue_item(input logic [7:0] b, input logic l);
      to_send.push_back('{data: b, last: l});
      items_queued++;
      if (l) strings_queued++;
   endtask

   task automatic queue_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         queue_item(text[i], i == text.len() - 1);
      end
   endtask

   function automatic logic [7:0] pick_hex_char();
      int unsigned k;
      k = $urandom_range(0, 21);
      if (k < 10) return 8'("0" + k);
      if (k < 16) return 8'("A" + k - 10);
      return 8'("a" + k - 16);
   endfunction

   function automatic logic [7:0] pick_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (hex_char(c));
      return c;
   endfunction

   // mostly well-formed escapes with random content, some noise and broken escapes
   task automatic queue_random_string();
      logic [7:0]  text[$];
      int unsigned tokens;
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               text.push_back(CharPercent);
               if ($urandom_range(0, 7) == 0) begin
                  text.push_back("0");
                  text.push_back("0");
               end else begin
                  text.push_back(pick_hex_char());
                  text.push_back(pick_hex_char());
               end
            end
            4: text.push_back(CharPlus);
            5, 6: text.push_back(8'($urandom_range(0, 255)));
            7: begin
               text.push_back(CharPercent);
               if ($urandom_range(0, 1)) text.push_back(pick_hex_char());
               text.push_back(pick_non_hex());
            end
            8: text.push_back(8'("a" + $urandom_range(0, 25)));
            default: text.push_back(CharPercent);
         endcase
      end
      // escape cut short by the end of the string
      case ($urandom_range(0, 5))
         0: text.push_back(CharPercent);
         1: begin
            text.push_back(CharPercent);
            text.push_back(pick_hex_char());
         end
         default: ;
      endcase
      foreach (text[i]) queue_item(text[i], i == text.size() - 1);
   endtask

   task automatic queue_random_phase(input int unsigned count);
      int unsigned stop_at;
      stop_at = items_queued + count;
      while (items_queued < stop_at) queue_random_string();
   endtask

   // idle means nothing left to send, nothing in flight and nothing owed
   task automatic wait_drained();
      while (to_send.size() != 0 || req_valid || expected_decoded.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == AddrStopOnZero) pred_stop_on_zero = data[0];
   endtask

   task automatic csr_check_stop_on_zero();
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= AddrStopOnZero;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[0] !== pred_stop_on_zero) begin
         $display("%0t: stop_on_zero readback mismatch expected %0b actual %0b",
                  $time, pred_stop_on_zero, csr_prdata[0]);
         fail_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- sender

   int unsigned burst_left = 1;
   int unsigned gap_left = 0;

   always @(posedge clock) begin : sender
      logic           offer;
      coded_byte_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         req_in_byte <= 8'h00;
         req_in_last <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            decode_byte(req_in_byte, req_in_last);
            items_taken++;
            offer = 1'b0;
         end
         // a held item keeps its payload, a new one goes out only after a take
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (to_send.size() > 0) begin
               next_item = to_send.pop_front();
               req_in_byte <= next_item.data;
               req_in_last <= next_item.last;
               offer = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 3) == 0) begin
                  // long stretch without gaps
                  burst_left = $urandom_range(30, 60);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 8);
                  gap_left = $urandom_range(0, 6);
               end
            end
         end
         req_valid <= offer;
      end
   end

   // ---------------------------------------------------------------- receiver stall

   stall_kind_type stall_kind = STALL_NONE;
   int unsigned    stall_seg_left = 0;
   int unsigned    stall_period = 2;
   int unsigned    holdoff_left = 0;
   int unsigned    holdoff_served = 0;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         // a long hold-off lets the block fill up and push back on its input
         if (holdoff_served != holdoff_requests) begin
            holdoff_served = holdoff_requests;
            holdoff_left = HoldoffCycles;
         end
         if (stall_seg_left == 0) begin
            stall_kind = stall_kind_type'($urandom_range(0, 3));
            stall_seg_left = $urandom_range(20, 120);
            stall_period = $urandom_range(2, 5);
         end else begin
            stall_seg_left--;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_kind)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
               default:     rsp_stall <= (stall_seg_left % stall_period == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- result check

   always @(posedge clock) begin : result_check
      plain_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_checked++;
         if (expected_decoded.size() == 0) begin
            $display("%0t: unexpected decoded byte expected none actual %02h last %0b",
                     $time, rsp_out_byte, rsp_out_last);
            fail_count++;
         end else begin
            want = expected_decoded.pop_front();
            if (rsp_out_byte !== want.data) begin
               $display("%0t: out_byte mismatch expected %02h actual %02h",
                        $time, want.data, rsp_out_byte);
               fail_count++;
            end
            if (rsp_out_last !== want.last) begin
               $display("%0t: out_last mismatch expected %0b actual %0b",
                        $time, want.last, rsp_out_last);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout, %0d decoded bytes still owed", $time,
                  expected_decoded.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, stop_on_zero at its reset value
      queue_text("+%4a%7E");      // plus, escapes in both cases
      queue_text("%fF");          // top byte value
      queue_item(8'h00, 1'b1);    // raw zero and raw ff pass through
      queue_item(8'hFF, 1'b1);
      queue_text("%");            // lone '%' as the last byte
      queue_text("%4");           // short escape at the end
      queue_text("%G1");          // broken escape after '%'
      queue_text("%4%41");        // broken after a digit, breaking byte opens a new escape
      queue_text("%00");          // encoded zero passes as a byte
      wait_drained();
      csr_check_stop_on_zero();

      // truncation on, a write past the register list must change nothing
      csr_write(AddrStopOnZero, 32'hFFFF_FFFF);
      csr_write(AddrBeyondList, 32'h0000_0000);
      csr_check_stop_on_zero();
      queue_text("%00a+");        // '%' closes the output, rest dropped
      queue_text("%00");          // encoded zero as the last bytes
      queue_text("x%2b");         // next string decodes normally again
      wait_drained();

      queue_random_phase(ItemsPerPhase);
      wait_drained();

      // truncation off, upper bits of the write data set
      csr_write(AddrStopOnZero, 32'hFFFF_FFFE);
      csr_check_stop_on_zero();
      queue_random_phase(ItemsPerPhase);
      holdoff_requests++;
      wait_drained();

      csr_write(AddrStopOnZero, 32'h0000_0001);
      csr_check_stop_on_zero();
      queue_random_phase(ItemsPerPhase);
      holdoff_requests++;
      wait_drained();

      repeat (8) @(posedge clock);
      if (expected_decoded.size() != 0) begin
         $display("%0t: %0d decoded bytes never arrived", $time, expected_decoded.size());
         fail_count++;
      end

      $display("run covered %0d encoded bytes in %0d strings, %0d decoded bytes checked",
               items_taken, strings_queued, bytes_checked);
      $display("stop_on_zero toggled both ways, %0d truncated strings, two long output hold-offs",
               truncations);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
